// ===== rtl/core/bldsr_pkg.sv =====
// Shared constants for the bounded list deque: operation codes, status codes
// and the widths of the request and result fields. No dependencies.
`timescale 1ns / 1ps

package bldsr_pkg;

  // default storage depth of the list
  localparam int CAPACITY_DEFAULT = 64;

  // field widths
  localparam int DATA_W    = 32;
  localparam int FUNC_W    = 3;
  localparam int FOUND_W   = 6;
  localparam int REMOVED_W = 7;
  localparam int STATUS_W  = 2;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE_ALL = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH     = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

endpackage

// ===== rtl/core/bounded_list_deque_search_remove.sv =====
// Top level of the bounded list deque with search and remove-all.
// Depends on bldsr_pkg and bldsr_ring.
`timescale 1ns / 1ps

// Bounded ordered list of signed 32-bit values, up to CAPACITY entries, kept
// as a ring in one synchronous memory with one read and one write port.
// One request is worked on at a time; a new request is taken while the last
// result still waits on the output register. Pops wait for the registered
// memory read before the result is built. Search and remove-all scan the
// live entries in order, and search stops at its first match; the scan
// reads one entry per cycle through the single read port, checks each
// entry in the cycle after its read, and ends once no read or check is
// left, while remove-all compacts the kept entries through the write port
// behind it. No clearing pass runs after reset.

module bounded_list_deque_search_remove #(
  parameter int CAPACITY = bldsr_pkg::CAPACITY_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bldsr_pkg::FUNC_W-1:0]        func,
  input  logic signed [bldsr_pkg::DATA_W-1:0] value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bldsr_pkg::DATA_W-1:0] popped_value,
  output logic [bldsr_pkg::FOUND_W-1:0]       found_index,
  output logic [bldsr_pkg::REMOVED_W-1:0]     removed_count,
  output logic [bldsr_pkg::STATUS_W-1:0]      status
);
  import bldsr_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(CAPACITY);
  localparam logic [AW-1:0] LAST_SLOT  = AW'(CAPACITY - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_POPW = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]               state;
  logic [FUNC_W-1:0]        op_func;
  logic [DATA_W-1:0]        op_value;
  logic [AW-1:0]            front;
  logic [CW-1:0]            count;
  logic [CW-1:0]            idx;
  logic [CW-1:0]            keep;
  logic                     pend;
  logic [AW-1:0]            pend_pos;
  logic signed [DATA_W-1:0] res_popped;
  logic [AW-1:0]            res_found;
  logic [CW-1:0]            res_removed;
  logic [STATUS_W-1:0]      res_status;

  logic              full;
  logic              empty;
  logic [CW-1:0]     cnt_m1;
  logic              scan_rd;
  logic              scan_match;
  logic              out_free;
  logic              rd_en;
  logic [AW-1:0]     rd_pos;
  logic [DATA_W-1:0] rd_data;
  logic              wr_en;
  logic [AW-1:0]     wr_pos;
  logic [DATA_W-1:0] wr_data;

  assign in_ready   = (state == S_IDLE);
  assign full       = (count == COUNT_FULL);
  assign empty      = (count == '0);
  assign cnt_m1     = count - 1'b1;
  assign scan_rd    = (idx < count);
  assign scan_match = pend && (rd_data == op_value);
  assign out_free   = !out_valid || out_ready;

  // memory access for the current step
  always_comb begin
    rd_en   = 1'b0;
    rd_pos  = '0;
    wr_en   = 1'b0;
    wr_pos  = '0;
    wr_data = op_value;
    case (state)
      S_EXEC: begin
        case (op_func)
          FUNC_PUSH_BACK: begin
            wr_en  = !full;
            wr_pos = count[AW-1:0];
          end
          FUNC_PUSH_FRONT: begin
            wr_en  = !full;
            wr_pos = LAST_SLOT;
          end
          FUNC_POP_BACK: begin
            rd_en  = !empty;
            rd_pos = cnt_m1[AW-1:0];
          end
          FUNC_POP_FRONT: begin
            rd_en  = !empty;
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        rd_en  = scan_rd;
        rd_pos = idx[AW-1:0];
        if (pend && (op_func == FUNC_REMOVE_ALL) && !scan_match) begin
          wr_en   = 1'b1;
          wr_pos  = keep[AW-1:0];
          wr_data = rd_data;
        end
      end
      default: begin
      end
    endcase
  end

  bldsr_ring #(
    .CAPACITY(CAPACITY),
    .AW      (AW)
  ) u_ring (
    .clk           (clk),
    .front_position(front),
    .rd_en         (rd_en),
    .rd_pos        (rd_pos),
    .rd_data       (rd_data),
    .wr_en         (wr_en),
    .wr_pos        (wr_pos),
    .wr_data       (wr_data)
  );

  // sequencer, list pointers and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // drop the taken result unless a new one is loaded in this cycle
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_func     <= func;
            op_value    <= value;
            idx         <= '0;
            keep        <= '0;
            pend        <= 1'b0;
            res_popped  <= '0;
            res_found   <= '0;
            res_removed <= '0;
            res_status  <= (func == FUNC_SEARCH) ? STATUS_NOT_FOUND : STATUS_OK;
            state       <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_DONE;
          case (op_func)
            FUNC_PUSH_BACK: begin
              if (full) begin
                res_status <= STATUS_FULL;
              end else begin
                count <= count + 1'b1;
              end
            end
            FUNC_PUSH_FRONT: begin
              if (full) begin
                res_status <= STATUS_FULL;
              end else begin
                front <= (front == '0) ? LAST_SLOT : front - 1'b1;
                count <= count + 1'b1;
              end
            end
            FUNC_POP_BACK: begin
              if (empty) begin
                res_status <= STATUS_EMPTY;
              end else begin
                count <= cnt_m1;
                state <= S_POPW;
              end
            end
            FUNC_POP_FRONT: begin
              if (empty) begin
                res_status <= STATUS_EMPTY;
              end else begin
                front <= (front == LAST_SLOT) ? '0 : front + 1'b1;
                count <= cnt_m1;
                state <= S_POPW;
              end
            end
            FUNC_REMOVE_ALL, FUNC_SEARCH: begin
              state <= S_SCAN;
            end
            default: begin
            end
          endcase
        end
        S_POPW: begin
          res_popped <= rd_data;
          state      <= S_DONE;
        end
        S_SCAN: begin
          // issue the next read while checking the previous one
          if (scan_rd) begin
            idx      <= idx + 1'b1;
            pend     <= 1'b1;
            pend_pos <= idx[AW-1:0];
          end else begin
            pend <= 1'b0;
          end
          if (op_func == FUNC_REMOVE_ALL) begin
            if (pend) begin
              if (scan_match) begin
                res_removed <= res_removed + 1'b1;
              end else begin
                keep <= keep + 1'b1;
              end
            end
            if (!pend && !scan_rd) begin
              count <= keep;
              state <= S_DONE;
            end
          end else begin
            if (scan_match) begin
              res_found  <= pend_pos;
              res_status <= STATUS_OK;
              pend       <= 1'b0;
              state      <= S_DONE;
            end else if (!pend && !scan_rd) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            popped_value  <= res_popped;
            found_index   <= FOUND_W'(res_found);
            removed_count <= REMOVED_W'(res_removed);
            status        <= res_status;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/bldsr_ring.sv =====
// Ring storage for the list: entry memory with one write and one read port,
// logical positions mapped to ring slots around the front slot. Uses bldsr_pkg.
`timescale 1ns / 1ps

module bldsr_ring #(
  parameter int CAPACITY = bldsr_pkg::CAPACITY_DEFAULT,
  parameter int AW       = $clog2(CAPACITY)
) (
  input  logic                        clk,
  input  logic [AW-1:0]               front_position,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_pos,
  output logic [bldsr_pkg::DATA_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_pos,
  input  logic [bldsr_pkg::DATA_W-1:0] wr_data
);
  import bldsr_pkg::*;

  localparam logic [AW:0] CAP_WIDE = (AW+1)'(CAPACITY);

  logic [DATA_W-1:0] mem [CAPACITY];

  logic [AW:0]   rd_sum;
  logic [AW:0]   wr_sum;
  logic [AW:0]   rd_wrap;
  logic [AW:0]   wr_wrap;
  logic [AW-1:0] rd_slot;
  logic [AW-1:0] wr_slot;

  // position to slot: front plus position, folded once past the end
  always_comb begin
    rd_sum  = {1'b0, front_position} + {1'b0, rd_pos};
    wr_sum  = {1'b0, front_position} + {1'b0, wr_pos};
    rd_wrap = (rd_sum >= CAP_WIDE) ? (rd_sum - CAP_WIDE) : rd_sum;
    wr_wrap = (wr_sum >= CAP_WIDE) ? (wr_sum - CAP_WIDE) : wr_sum;
    rd_slot = rd_wrap[AW-1:0];
    wr_slot = wr_wrap[AW-1:0];
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_slot];
    end
  end

endmodule
